[design/flash_program_erase_controller_macros.svh]
// ----------------------------------------------------------------------------
// Flash program/erase controller assertion macros
// Shared concurrent assertion forms for the controller's checker.
// ----------------------------------------------------------------------------
`ifndef FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH
`define FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH

// Assertion that is switched off while reset is held.
`define FPEC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define FPEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fpec_pkg.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller package
// Request and register codes, key words, control bit positions and the
// classified command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package fpec_pkg;

  // Request types.
  localparam logic [1:0] REQ_REG_WR   = 2'd0;
  localparam logic [1:0] REQ_REG_RD   = 2'd1;
  localparam logic [1:0] REQ_FLASH_RD = 2'd2;
  localparam logic [1:0] REQ_INVALID  = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_CLR  = 3'd1;
  localparam logic [2:0] REG_SET  = 3'd2;
  localparam logic [2:0] REG_KEY  = 3'd3;
  localparam logic [2:0] REG_ADDR = 3'd4;
  localparam logic [2:0] REG_DLO  = 3'd5;
  localparam logic [2:0] REG_DHI  = 3'd6;

  // Unlock key words.
  localparam logic [31:0] KEY_FIRST  = 32'haa996655;
  localparam logic [31:0] KEY_SECOND = 32'h556699aa;

  // Operation codes.
  localparam logic [3:0] OP_DWORD = 4'h2;
  localparam logic [3:0] OP_ERASE = 4'h4;

  // Control register bit positions.
  localparam int BIT_ERR   = 13;
  localparam int BIT_WREN  = 14;
  localparam int BIT_START = 15;

  // Command as classified by the front end.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_index;
    logic [31:0] write_value;
    logic [9:0]  flash_word_index;
    logic        flash_in_range;
    logic        start;
    logic        key_first;
    logic        key_second;
  } cmd_t;

endpackage

`default_nettype wire

[design/fpec_if.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller channels
// Valid/ready channel for bus accesses and for their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  reg_index;
  logic [31:0] write_value;
  logic [9:0]  flash_word_index;

  modport source (output valid, output req_type, output reg_index,
                  output write_value, output flash_word_index, input ready);
  modport sink (input valid, input req_type, input reg_index,
                input write_value, input flash_word_index, output ready);
endinterface

interface fpec_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic        error_flag;

  modport source (output valid, output read_value, output error_flag, input ready);
  modport sink (input valid, input read_value, input error_flag, output ready);
endinterface

`default_nettype wire

[design/flash_program_erase_controller.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller
// A flash array of FLASH_WORDS 64-bit words behind a control register with
// clear and set aliases, an unlock key register, an address register and two
// data registers; every accepted beat returns exactly one result beat. After
// reset the controller erases the array once, one word a cycle, and holds
// in_ch.ready low meanwhile. Beats enter a two-entry queue and the back end
// takes one per cycle when it is idle and its output register is free, so a
// register access result passes through the queue and the output register,
// and a flash read or program result also through the registered RAM read.
// A register access is done in the idle state; a flash read or a doubleword
// program goes on to its own state (the RAM read is registered, and program
// is a read-modify-write), and a page erase of up to PAGE_WORDS words writes
// one word a cycle through the single RAM write port.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_program_erase_controller import fpec_pkg::*; #(
  parameter int FLASH_WORDS = 1024,
  parameter int PAGE_WORDS  = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpec_in_if.sink    in_ch,
  fpec_out_if.source out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic accept_en;

  // Front end: accept and classify beats.
  fpec_front #(
    .FLASH_WORDS (FLASH_WORDS)
  ) u_fpec_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .accept_en (accept_en),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Back end: registers, flash array and result register.
  fpec_back #(
    .FLASH_WORDS (FLASH_WORDS),
    .PAGE_WORDS  (PAGE_WORDS)
  ) u_fpec_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .accept_en (accept_en),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[design/fpec_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/fpec_front.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller front end
// Accepts bus beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpec_front import fpec_pkg::*; #(
  parameter int FLASH_WORDS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpec_in_if.sink    in_ch,
  input  wire logic  accept_en,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_ready
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cls;
  logic       push;
  logic       pop;
  logic       is_wr;

  // Classify the incoming beat.
  always_comb begin
    is_wr                = (in_ch.req_type == REQ_REG_WR);
    cls.req_type         = in_ch.req_type;
    cls.reg_index        = in_ch.reg_index;
    cls.write_value      = in_ch.write_value;
    cls.flash_word_index = in_ch.flash_word_index;
    cls.flash_in_range   = ({22'd0, in_ch.flash_word_index} < 32'(FLASH_WORDS));
    cls.start            = is_wr && ((in_ch.reg_index == REG_CTRL) ||
                                     (in_ch.reg_index == REG_SET)) &&
                           in_ch.write_value[BIT_START];
    cls.key_first        = is_wr && (in_ch.reg_index == REG_KEY) &&
                           (in_ch.write_value == KEY_FIRST);
    cls.key_second       = is_wr && (in_ch.reg_index == REG_KEY) &&
                           (in_ch.write_value == KEY_SECOND);
  end

  // Queue handshakes.
  assign in_ch.ready = accept_en && (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

[design/fpec_back.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller back end
// Holds the register bank and the flash array, carries out commands from the
// queue and presents one result per command in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpec_back import fpec_pkg::*; #(
  parameter int FLASH_WORDS = 1024,
  parameter int PAGE_WORDS  = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cmd_t  cmd,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  output logic       accept_en,
  fpec_out_if.source out_ch
);

  localparam int AW = $clog2(FLASH_WORDS);
  localparam int CW = $clog2(PAGE_WORDS);
  // Reciprocal of the page size, rounded up, for the page alignment check.
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(PAGE_WORDS) - 64'd1) / 64'(PAGE_WORDS);
  localparam logic [31:0] RECIP = 32'(RECIP_L);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FRD   = 3'd2;
  localparam logic [2:0] ST_PROG  = 3'd3;
  localparam logic [2:0] ST_ERASE = 3'd4;

  // Unlock stages.
  localparam logic [1:0] UNL_NONE = 2'd0;
  localparam logic [1:0] UNL_HALF = 2'd1;
  localparam logic [1:0] UNL_FULL = 2'd2;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    op_r, op_nxt;
  logic          wren_r, wren_nxt;
  logic          err_r, err_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic          dw_ok_r, dw_ok_nxt;
  logic          pg_ok_r, pg_ok_nxt;
  logic [31:0]   dlo_r, dlo_nxt;
  logic [31:0]   dhi_r, dhi_nxt;
  logic [1:0]    stage_r, stage_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_val_r, out_val_nxt;
  logic          out_err_r, out_err_nxt;

  logic          out_free;
  logic          out_load;
  logic [63:0]   load_val;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  logic [AW-1:0] addr_word;
  logic [31:0]   align_prod;
  logic          word_fits;
  logic          op_ok;
  logic [63:0]   ctrl_word;

  fpec_ram #(
    .WIDTH (64),
    .DEPTH (FLASH_WORDS)
  ) u_fpec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept_en      = (state_r != ST_CLEAR);
  assign out_free       = !out_valid_r || out_ch.ready;
  assign addr_word      = addr_r[3 +: AW];
  assign ctrl_word      = {48'd0, 1'b0, wren_r, err_r, 9'd0, op_r};
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_val_r;
  assign out_ch.error_flag = out_err_r;

  // Alignment of a new address: in range, doubleword and page alignment.
  always_comb begin
    word_fits  = (cmd.write_value[31:3] < 29'(FLASH_WORDS));
    align_prod = 32'(cmd.write_value[3 +: AW]) * RECIP;
  end

  // Command sequencer.
  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    wren_nxt  = wren_r;
    err_nxt   = err_r;
    addr_nxt  = addr_r;
    dw_ok_nxt = dw_ok_r;
    pg_ok_nxt = pg_ok_r;
    dlo_nxt   = dlo_r;
    dhi_nxt   = dhi_r;
    stage_nxt = stage_r;
    cmd_ready = 1'b0;
    out_load  = 1'b0;
    load_val  = 64'd0;
    ram_we    = 1'b0;
    ram_waddr = walk_r;
    ram_wdata = '1;
    ram_raddr = AW'(cmd.flash_word_index);
    op_ok     = 1'b0;

    case (state_r)
      // Erase the whole array after reset.
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (walk_r == AW'(FLASH_WORDS - 1)) begin
          walk_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_r + AW'(1);
        end
      end

      // Take one command when the output register can receive its result.
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          if (cmd.key_first) begin
            stage_nxt = UNL_HALF;
          end else if (cmd.key_second && (stage_r == UNL_HALF)) begin
            stage_nxt = UNL_FULL;
          end else begin
            stage_nxt = UNL_NONE;
          end

          case (cmd.req_type)
            REQ_REG_WR: begin
              case (cmd.reg_index)
                REG_CTRL: begin
                  op_nxt   = cmd.write_value[3:0];
                  wren_nxt = cmd.write_value[BIT_WREN];
                end
                REG_CLR: begin
                  op_nxt = op_r & ~cmd.write_value[3:0];
                  if (cmd.write_value[BIT_WREN]) begin
                    wren_nxt = 1'b0;
                  end
                end
                REG_SET: begin
                  op_nxt = op_r | cmd.write_value[3:0];
                  if (cmd.write_value[BIT_WREN]) begin
                    wren_nxt = 1'b1;
                  end
                end
                REG_ADDR: begin
                  addr_nxt  = cmd.write_value;
                  dw_ok_nxt = (cmd.write_value[2:0] == 3'd0) && word_fits;
                  pg_ok_nxt = (cmd.write_value[2:0] == 3'd0) && word_fits &&
                              (align_prod < RECIP);
                end
                REG_DLO: begin
                  dlo_nxt = cmd.write_value;
                end
                REG_DHI: begin
                  dhi_nxt = cmd.write_value;
                end
                default: begin
                end
              endcase

              // Start attempt, judged after the write has taken effect.
              op_ok = (stage_r == UNL_FULL) && wren_nxt &&
                      (((op_nxt == OP_ERASE) && pg_ok_r) ||
                       ((op_nxt == OP_DWORD) && dw_ok_r));
              if (cmd.start) begin
                err_nxt = !op_ok;
              end
              if (cmd.start && op_ok && (op_nxt == OP_ERASE)) begin
                walk_nxt  = addr_word;
                cnt_nxt   = '0;
                state_nxt = ST_ERASE;
              end else if (cmd.start && op_ok) begin
                ram_raddr = addr_word;
                state_nxt = ST_PROG;
              end else begin
                out_load = 1'b1;
              end
            end
            REQ_REG_RD: begin
              out_load = 1'b1;
              case (cmd.reg_index)
                REG_CTRL: load_val = ctrl_word;
                REG_ADDR: load_val = {32'd0, addr_r};
                REG_DLO:  load_val = {32'd0, dlo_r};
                REG_DHI:  load_val = {32'd0, dhi_r};
                default:  load_val = 64'd0;
              endcase
            end
            REQ_FLASH_RD: begin
              if (cmd.flash_in_range) begin
                state_nxt = ST_FRD;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // Flash read data arrives from the registered RAM port.
      ST_FRD: begin
        out_load  = 1'b1;
        load_val  = ram_rdata;
        state_nxt = ST_IDLE;
      end

      // Doubleword program: AND the data registers into the old word.
      ST_PROG: begin
        ram_we    = 1'b1;
        ram_waddr = addr_word;
        ram_wdata = ram_rdata & {dhi_r, dlo_r};
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end

      // Page erase: one word a cycle, stopping at the end of the page or of the array.
      ST_ERASE: begin
        ram_we = 1'b1;
        if ((cnt_r == CW'(PAGE_WORDS - 1)) || (walk_r == AW'(FLASH_WORDS - 1))) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_r + AW'(1);
          cnt_nxt  = cnt_r + CW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = load_val;
      out_err_nxt   = err_nxt;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_r      <= '0;
      cnt_r       <= '0;
      op_r        <= 4'd0;
      wren_r      <= 1'b0;
      err_r       <= 1'b0;
      addr_r      <= 32'd0;
      dw_ok_r     <= 1'b1;
      pg_ok_r     <= 1'b1;
      dlo_r       <= 32'd0;
      dhi_r       <= 32'd0;
      stage_r     <= UNL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      wren_r      <= wren_nxt;
      err_r       <= err_nxt;
      addr_r      <= addr_nxt;
      dw_ok_r     <= dw_ok_nxt;
      pg_ok_r     <= pg_ok_nxt;
      dlo_r       <= dlo_nxt;
      dhi_r       <= dhi_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

`default_nettype wire

[design/fpec_checker.sv]
// ----------------------------------------------------------------------------
// Flash program/erase controller checker
// Port-level checks on reset behavior, stalled-result stability, result accounting and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flash_program_erase_controller_macros.svh"

module fpec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_read_value,
  input wire logic        out_error_flag
);

  logic [2:0] outstanding_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Beats accepted but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= 3'd0;
    end else begin
      outstanding_r <= outstanding_r + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  `FPEC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !in_ready && !out_valid, "ports active after reset")
  `FPEC_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_error_flag), "stalled result changed")
  `FPEC_ASSERT_RST(a_no_extra_result, clk, rst_n, out_valid |-> outstanding_r != 3'd0, "result without an accepted beat")
  `FPEC_ASSERT_RST(a_occupancy, clk, rst_n, in_acc |-> outstanding_r <= 3'd2, "beat accepted beyond queue depth")

endmodule

bind flash_program_erase_controller fpec_checker u_fpec_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_error_flag (out_ch.error_flag)
);

`default_nettype wire
